// ===== rtl/lzf_pkg.sv =====
// shared types, constants and helpers of the relative lz factoriser
// no dependencies; every other file imports this package
`timescale 1ns / 1ps
`default_nettype none

package lzf_pkg;

    // store geometry and field widths
    localparam int unsigned REF_LEN_MAX = 65536;
    localparam int unsigned IDX_W       = 17;
    localparam int unsigned LEN_W       = 32;
    localparam int unsigned CODE_W      = 3;
    localparam int unsigned SRCH_W      = 18;

    localparam logic [IDX_W-1:0] REF_MAX_IDX = IDX_W'(REF_LEN_MAX);
    localparam logic [LEN_W-1:0] LEN_LIMIT   = {LEN_W{1'b1}};

    // ascii of the lower-case n that forms runs
    localparam logic [7:0] CHAR_LOWER_N = 8'h6E;

    typedef enum logic [1:0] {
        REQ_LOAD_REF = 2'd0,
        REQ_LOAD_SA  = 2'd1,
        REQ_SYMBOL   = 2'd2,
        REQ_END      = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        STS_FACTOR   = 2'd0,
        STS_BAD_BYTE = 2'd1,
        STS_ABSENT   = 2'd2
    } t_sts;

    // datapath operations, one per cycle
    typedef enum logic [4:0] {
        OP_NOP,
        OP_LATCH,
        OP_WRITE,
        OP_RESTART,
        OP_INIT,
        OP_MID,
        OP_RD_SA,
        OP_RD_REF,
        OP_RD_REF_NB,
        OP_GO_LEFT,
        OP_GO_RIGHT,
        OP_FOUND,
        OP_NEIGHBOR,
        OP_COMMIT,
        OP_N_STEP,
        OP_EMIT_N,
        OP_EMIT_SA,
        OP_EMIT_INV,
        OP_EMIT_ABS,
        OP_FINISH
    } t_op;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_EMIT_RUN,
        ST_INIT,
        ST_MID,
        ST_SA,
        ST_REF,
        ST_CMP,
        ST_NSA,
        ST_NREF,
        ST_NCMP,
        ST_FAIL,
        ST_EMIT_MIS,
        ST_EMIT_ABS,
        ST_COMMIT,
        ST_LIMIT,
        ST_EMIT_LIM,
        ST_EMIT_PRE_N,
        ST_N_STEP,
        ST_N_LIM,
        ST_EMIT_NLIM,
        ST_EMIT_EOS,
        ST_EMIT_INV,
        ST_FINISH
    } t_state;

    typedef struct packed {
        t_op  op;
        logic cfg_wr;
    } t_cmd;

    typedef struct packed {
        t_req req;
        logic sym_invalid;
        logic sym_is_n;
        logic in_run;
        logic ml_zero;
        logic ml_at_limit;
        logic retried;
        logic range_empty;
        logic lt;
        logic gt;
        logic at_edge;
        logic nb_differs;
        logic second;
        logic pend_valid;
        logic out_free;
    } t_status;

    // ascii nucleotide to base code, zero for anything else
    function automatic logic [CODE_W-1:0] base_code(input logic [7:0] b);
        logic [CODE_W-1:0] c;
        unique case (b)
            8'h61, 8'h41: c = 3'd1; // a
            8'h63, 8'h43: c = 3'd2; // c
            8'h67, 8'h47: c = 3'd3; // g
            8'h6E, 8'h4E: c = 3'd4; // n
            8'h74, 8'h54: c = 3'd5; // t
            default:      c = 3'd0;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/lzf_if.sv =====
// handshake channels of the factoriser: input items, config writes, results
// depends on lzf_pkg
`timescale 1ns / 1ps
`default_nettype none

interface lzf_in_if;
    import lzf_pkg::*;
    logic                valid;
    logic                ready;
    logic [1:0]          req_type;
    logic [IDX_W-1:0]    load_index;
    logic [IDX_W-1:0]    load_value;
    logic [7:0]          symbol_byte;
    modport source (output valid, req_type, load_index, load_value, symbol_byte,
                    input ready);
    modport sink (input valid, req_type, load_index, load_value, symbol_byte,
                  output ready);
endinterface

interface lzf_cfg_if;
    import lzf_pkg::*;
    logic                valid;
    logic                ready;
    logic [IDX_W-1:0]    data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

interface lzf_out_if;
    import lzf_pkg::*;
    logic                valid;
    logic                ready;
    logic [IDX_W-1:0]    factor_position;
    logic [LEN_W-1:0]    factor_length;
    logic [1:0]          status_code;
    logic                last_of_item;
    modport source (output valid, factor_position, factor_length, status_code,
                    last_of_item, input ready);
    modport sink (input valid, factor_position, factor_length, status_code,
                  last_of_item, output ready);
endinterface

`default_nettype wire

// ===== rtl/lzf_ctrl.sv =====
// controller of the factoriser: sequences loads, binary searches and results
// depends on lzf_pkg; drives lzf_dp through t_cmd and reads t_status
`timescale 1ns / 1ps
`default_nettype none

module lzf_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic             i_cfg_valid,
    input  wire lzf_pkg::t_status i_sts,
    output lzf_pkg::t_cmd         o_cmd,
    output logic                  o_in_ready,
    output logic                  o_cfg_ready
);
    import lzf_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   w_can_emit;

    // a result may move when the pending slot can drain
    assign w_can_emit = !i_sts.pend_valid || i_sts.out_free;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_DISPATCH;
            end
            ST_DISPATCH: begin
                unique case (i_sts.req)
                    REQ_LOAD_REF, REQ_LOAD_SA: n_state = ST_IDLE;
                    REQ_END: n_state = i_sts.ml_zero ? ST_FINISH : ST_EMIT_EOS;
                    REQ_SYMBOL: begin
                        priority if (i_sts.sym_invalid) n_state = ST_EMIT_INV;
                        else if (i_sts.sym_is_n) begin
                            n_state = (!i_sts.in_run && !i_sts.ml_zero)
                                      ? ST_EMIT_PRE_N : ST_N_STEP;
                        end else begin
                            n_state = i_sts.in_run ? ST_EMIT_RUN : ST_INIT;
                        end
                    end
                    default: n_state = ST_IDLE;
                endcase
            end
            ST_EMIT_RUN:   if (w_can_emit) n_state = ST_INIT;
            ST_INIT:       n_state = ST_MID;
            ST_MID:        n_state = i_sts.range_empty ? ST_FAIL : ST_SA;
            ST_SA:         n_state = ST_REF;
            ST_REF:        n_state = ST_CMP;
            ST_CMP: begin
                priority if (i_sts.lt || i_sts.gt) n_state = ST_MID;
                else if (i_sts.at_edge) n_state = i_sts.second ? ST_COMMIT : ST_MID;
                else n_state = ST_NSA;
            end
            ST_NSA:        n_state = ST_NREF;
            ST_NREF:       n_state = ST_NCMP;
            ST_NCMP: begin
                n_state = (i_sts.nb_differs && i_sts.second) ? ST_COMMIT : ST_MID;
            end
            ST_FAIL: begin
                n_state = (!i_sts.retried && !i_sts.ml_zero) ? ST_EMIT_MIS : ST_EMIT_ABS;
            end
            ST_EMIT_MIS:   if (w_can_emit) n_state = ST_INIT;
            ST_EMIT_ABS:   if (w_can_emit) n_state = ST_FINISH;
            ST_COMMIT:     n_state = ST_LIMIT;
            ST_LIMIT:      n_state = i_sts.ml_at_limit ? ST_EMIT_LIM : ST_FINISH;
            ST_EMIT_LIM:   if (w_can_emit) n_state = ST_FINISH;
            ST_EMIT_PRE_N: if (w_can_emit) n_state = ST_N_STEP;
            ST_N_STEP:     n_state = ST_N_LIM;
            ST_N_LIM:      n_state = i_sts.ml_at_limit ? ST_EMIT_NLIM : ST_FINISH;
            ST_EMIT_NLIM:  if (w_can_emit) n_state = ST_FINISH;
            ST_EMIT_EOS:   if (w_can_emit) n_state = ST_FINISH;
            ST_EMIT_INV:   if (w_can_emit) n_state = ST_FINISH;
            ST_FINISH:     if (w_can_emit) n_state = ST_IDLE;
            default:       n_state = ST_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd.op     = OP_NOP;
        o_cmd.cfg_wr = 1'b0;
        o_in_ready   = (r_state == ST_IDLE);
        o_cfg_ready  = (r_state == ST_IDLE);
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.cfg_wr = i_cfg_valid;
                if (i_in_valid) o_cmd.op = OP_LATCH;
            end
            ST_DISPATCH: begin
                if (i_sts.req == REQ_LOAD_REF || i_sts.req == REQ_LOAD_SA) begin
                    o_cmd.op = OP_WRITE;
                end else if (i_sts.req == REQ_END && i_sts.ml_zero) begin
                    o_cmd.op = OP_RESTART;
                end
            end
            ST_EMIT_RUN:   if (w_can_emit) o_cmd.op = OP_EMIT_N;
            ST_INIT:       o_cmd.op = OP_INIT;
            ST_MID:        if (!i_sts.range_empty) o_cmd.op = OP_MID;
            ST_SA, ST_NSA: o_cmd.op = OP_RD_SA;
            ST_REF:        o_cmd.op = OP_RD_REF;
            ST_NREF:       o_cmd.op = OP_RD_REF_NB;
            ST_CMP: begin
                priority if (i_sts.lt) o_cmd.op = OP_GO_RIGHT;
                else if (i_sts.gt) o_cmd.op = OP_GO_LEFT;
                else if (i_sts.at_edge) o_cmd.op = OP_FOUND;
                else o_cmd.op = OP_NEIGHBOR;
            end
            ST_NCMP: begin
                priority if (i_sts.nb_differs) o_cmd.op = OP_FOUND;
                else if (i_sts.second) o_cmd.op = OP_GO_RIGHT;
                else o_cmd.op = OP_GO_LEFT;
            end
            ST_EMIT_MIS, ST_EMIT_LIM, ST_EMIT_PRE_N: begin
                if (w_can_emit) o_cmd.op = OP_EMIT_SA;
            end
            ST_EMIT_ABS:   if (w_can_emit) o_cmd.op = OP_EMIT_ABS;
            ST_COMMIT:     o_cmd.op = OP_COMMIT;
            ST_N_STEP:     o_cmd.op = OP_N_STEP;
            ST_EMIT_NLIM:  if (w_can_emit) o_cmd.op = OP_EMIT_N;
            ST_EMIT_EOS: begin
                if (w_can_emit) o_cmd.op = i_sts.in_run ? OP_EMIT_N : OP_EMIT_SA;
            end
            ST_EMIT_INV:   if (w_can_emit) o_cmd.op = OP_EMIT_INV;
            ST_FINISH:     if (w_can_emit) o_cmd.op = OP_FINISH;
            ST_FAIL, ST_LIMIT, ST_N_LIM: o_cmd.op = OP_NOP;
            default:       o_cmd.op = OP_NOP;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/lzf_dp.sv =====
// datapath of the factoriser: reference and suffix stores, search bounds,
// match state and the pending/output result registers; depends on lzf_pkg
`timescale 1ns / 1ps
`default_nettype none

module lzf_dp (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire lzf_pkg::t_cmd             i_cmd,
    input  wire logic [1:0]                i_req_type,
    input  wire logic [lzf_pkg::IDX_W-1:0] i_load_index,
    input  wire logic [lzf_pkg::IDX_W-1:0] i_load_value,
    input  wire logic [7:0]                i_symbol_byte,
    input  wire logic [lzf_pkg::IDX_W-1:0] i_cfg_data,
    input  wire logic                      i_out_ready,
    output lzf_pkg::t_status               o_sts,
    output logic                           o_out_valid,
    output logic [lzf_pkg::IDX_W-1:0]      o_factor_position,
    output logic [lzf_pkg::LEN_W-1:0]      o_factor_length,
    output logic [1:0]                     o_status_code,
    output logic                           o_last_of_item
);
    import lzf_pkg::*;

    // stores, undefined until loaded
    logic [CODE_W-1:0] r_ref_mem [0:REF_LEN_MAX];
    logic [IDX_W-1:0]  r_sa_mem  [0:REF_LEN_MAX];

    // latched item
    t_req              r_req;
    logic [IDX_W-1:0]  r_idx;
    logic [IDX_W-1:0]  r_val;
    logic [7:0]        r_byte;

    // match state
    logic [IDX_W-1:0]  r_ref_length;
    logic [IDX_W-1:0]  r_left;
    logic [IDX_W-1:0]  r_right;
    logic [IDX_W-1:0]  r_left_sa;
    logic [LEN_W-1:0]  r_ml;
    logic              r_run;
    logic              r_retried;

    // search state
    logic signed [SRCH_W-1:0] r_lo;
    logic signed [SRCH_W-1:0] r_hi;
    logic [IDX_W-1:0]  r_pl;
    logic [IDX_W-1:0]  r_pr;
    logic [IDX_W-1:0]  r_mid;
    logic [IDX_W-1:0]  r_addr;
    logic              r_second;
    logic [IDX_W-1:0]  r_cl;
    logic [IDX_W-1:0]  r_cl_sa;
    logic [IDX_W-1:0]  r_mid_sa;

    // registered store reads
    logic [IDX_W-1:0]  r_sa_raw;
    logic              r_sa_oob;
    logic [CODE_W-1:0] r_ref_raw;
    logic              r_ref_oob;

    // pending and output results
    logic              r_pend_valid;
    logic [IDX_W-1:0]  r_pend_pos;
    logic [LEN_W-1:0]  r_pend_len;
    t_sts              r_pend_sts;
    logic              r_out_valid;
    logic [IDX_W-1:0]  r_out_pos;
    logic [LEN_W-1:0]  r_out_len;
    t_sts              r_out_sts;
    logic              r_out_last;

    logic [IDX_W-1:0]  w_sa_val;
    logic [CODE_W-1:0] w_code_val;
    logic [CODE_W-1:0] w_sym_code;
    logic [IDX_W:0]    w_ref_pos;
    logic [LEN_W:0]    w_probe;
    logic [SRCH_W:0]   w_mid_sum;
    logic [IDX_W-1:0]  w_cfg_len;
    logic              w_emit;
    logic [IDX_W-1:0]  w_new_pos;
    logic [LEN_W-1:0]  w_new_len;
    t_sts              w_new_sts;
    logic              w_push;
    logic              w_out_free;

    assign w_sa_val   = r_sa_oob ? '0 : r_sa_raw;
    assign w_code_val = r_ref_oob ? '0 : r_ref_raw;
    assign w_sym_code = base_code(r_byte);
    assign w_probe    = {{(LEN_W + 1 - IDX_W){1'b0}}, w_sa_val} + {1'b0, r_ml};
    assign w_ref_pos  = w_probe[IDX_W:0];
    assign w_mid_sum  = {r_lo[SRCH_W-1], r_lo} + {r_hi[SRCH_W-1], r_hi};
    assign w_cfg_len  = (i_cfg_data > REF_MAX_IDX) ? REF_MAX_IDX : i_cfg_data;
    assign w_out_free = !r_out_valid || i_out_ready;

    // result built by an emit operation
    always_comb begin
        w_emit    = 1'b1;
        w_new_pos = '0;
        w_new_len = '0;
        w_new_sts = STS_FACTOR;
        unique case (i_cmd.op)
            OP_EMIT_N: begin
                w_new_pos = r_ref_length;
                w_new_len = r_ml;
            end
            OP_EMIT_SA: begin
                w_new_pos = r_left_sa;
                w_new_len = r_ml;
            end
            OP_EMIT_INV: w_new_sts = STS_BAD_BYTE;
            OP_EMIT_ABS: w_new_sts = STS_ABSENT;
            default:     w_emit = 1'b0;
        endcase
    end

    // pending result moves out on a new emit or at the end of an item
    assign w_push = r_pend_valid && (w_emit || i_cmd.op == OP_FINISH);

    // store writes and reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_WRITE && r_idx <= REF_MAX_IDX) begin
            if (r_req == REQ_LOAD_REF) r_ref_mem[r_idx] <= r_val[CODE_W-1:0];
            if (r_req == REQ_LOAD_SA)  r_sa_mem[r_idx]  <= r_val;
        end
        if (i_cmd.op == OP_RD_SA) begin
            r_sa_raw <= r_sa_mem[r_addr];
        end
        if (i_cmd.op == OP_RD_REF || i_cmd.op == OP_RD_REF_NB) begin
            r_ref_raw <= r_ref_mem[w_ref_pos[IDX_W-1:0]];
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LATCH: begin
                r_req  <= t_req'(i_req_type);
                r_idx  <= i_load_index;
                r_val  <= i_load_value;
                r_byte <= i_symbol_byte;
            end
            OP_INIT: begin
                r_lo <= SRCH_W'(r_left);
                r_hi <= SRCH_W'(r_right);
                r_pl <= r_left;
                r_pr <= r_right;
            end
            OP_MID: begin
                r_mid  <= w_mid_sum[IDX_W:1];
                r_addr <= w_mid_sum[IDX_W:1];
            end
            OP_RD_SA: r_sa_oob <= (r_addr > REF_MAX_IDX);
            OP_RD_REF: begin
                r_ref_oob <= (w_probe > (LEN_W + 1)'(REF_LEN_MAX));
                r_mid_sa  <= w_sa_val;
            end
            OP_RD_REF_NB: r_ref_oob <= (w_probe > (LEN_W + 1)'(REF_LEN_MAX));
            OP_GO_LEFT:   r_hi <= SRCH_W'(r_mid) - SRCH_W'(1);
            OP_GO_RIGHT:  r_lo <= SRCH_W'(r_mid) + SRCH_W'(1);
            OP_FOUND: begin
                if (!r_second) begin
                    r_cl    <= r_mid;
                    r_cl_sa <= r_mid_sa;
                    r_lo    <= SRCH_W'(r_mid);
                    r_hi    <= SRCH_W'(r_pr);
                end
            end
            OP_NEIGHBOR: r_addr <= r_second ? r_mid + IDX_W'(1) : r_mid - IDX_W'(1);
            default: ;
        endcase
        if (w_emit) begin
            r_pend_pos <= w_new_pos;
            r_pend_len <= w_new_len;
            r_pend_sts <= w_new_sts;
        end
        if (w_push) begin
            r_out_pos  <= r_pend_pos;
            r_out_len  <= r_pend_len;
            r_out_sts  <= r_pend_sts;
            r_out_last <= (i_cmd.op == OP_FINISH);
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_length <= REF_MAX_IDX;
            r_left       <= '0;
            r_right      <= REF_MAX_IDX;
            r_left_sa    <= '0;
            r_ml         <= '0;
            r_run        <= 1'b0;
            r_retried    <= 1'b0;
            r_second     <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            // match state updates
            unique case (i_cmd.op)
                OP_LATCH:   r_retried <= 1'b0;
                OP_RESTART, OP_EMIT_N: begin
                    r_left  <= '0;
                    r_right <= r_ref_length;
                    r_ml    <= '0;
                    r_run   <= 1'b0;
                end
                OP_EMIT_SA: begin
                    r_left    <= '0;
                    r_right   <= r_ref_length;
                    r_ml      <= '0;
                    r_run     <= 1'b0;
                    r_retried <= 1'b1;
                end
                OP_EMIT_ABS: r_ml <= '0;
                OP_INIT:     r_second <= 1'b0;
                OP_FOUND:    r_second <= 1'b1;
                OP_COMMIT: begin
                    r_left    <= r_cl;
                    r_right   <= r_mid;
                    r_left_sa <= r_cl_sa;
                    r_ml      <= r_ml + LEN_W'(1);
                end
                OP_N_STEP: begin
                    r_run <= 1'b1;
                    r_ml  <= r_ml + LEN_W'(1);
                end
                default: ;
            endcase
            // config write restarts against the new length
            if (i_cmd.cfg_wr) begin
                r_ref_length <= w_cfg_len;
                r_left       <= '0;
                r_right      <= w_cfg_len;
                r_ml         <= '0;
                r_run        <= 1'b0;
            end
            // pending slot
            if (w_emit) r_pend_valid <= 1'b1;
            else if (w_push) r_pend_valid <= 1'b0;
            // output register
            if (w_push) r_out_valid <= 1'b1;
            else if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;
        end
    end

    // status to the controller
    always_comb begin
        o_sts.req         = r_req;
        o_sts.sym_invalid = (w_sym_code == '0);
        o_sts.sym_is_n    = (r_byte == CHAR_LOWER_N);
        o_sts.in_run      = r_run;
        o_sts.ml_zero     = (r_ml == '0);
        o_sts.ml_at_limit = (r_ml >= LEN_LIMIT);
        o_sts.retried     = r_retried;
        o_sts.range_empty = (r_lo > r_hi);
        o_sts.lt          = (w_code_val < w_sym_code);
        o_sts.gt          = (w_code_val > w_sym_code);
        o_sts.at_edge     = (r_mid == (r_second ? r_pr : r_pl));
        o_sts.nb_differs  = (w_code_val != w_sym_code);
        o_sts.second      = r_second;
        o_sts.pend_valid  = r_pend_valid;
        o_sts.out_free    = w_out_free;
    end

    assign o_out_valid       = r_out_valid;
    assign o_factor_position = r_out_pos;
    assign o_factor_length   = r_out_len;
    assign o_status_code     = r_out_sts;
    assign o_last_of_item    = r_out_last;

endmodule

`default_nettype wire

// ===== rtl/relative_lz_factoriser_unit.sv =====
// sequence: a load is latched, then written; a symbol, after any pending n run result is emitted,
// runs a pair of binary searches of up to 17 probes each, a probe also checking the neighbor entry
// when needed; a mismatch adds a result and a second pair of searches
// throughput: one item at a time; a new item is accepted only in the idle state
// reset: synchronous active-low; ref_length 65536, interval full, no match pending;
// the stores are not cleared and hold garbage until loaded
`timescale 1ns / 1ps
`default_nettype none

module relative_lz_factoriser_unit (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    lzf_in_if.sink     i_in,
    lzf_cfg_if.sink    i_cfg,
    lzf_out_if.source  o_out
);
    import lzf_pkg::*;

    t_cmd    w_cmd;
    t_status w_sts;

    // sequencer
    lzf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_cfg_valid (i_cfg.valid),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd),
        .o_in_ready  (i_in.ready),
        .o_cfg_ready (i_cfg.ready)
    );

    // stores, search and result registers
    lzf_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .i_req_type        (i_in.req_type),
        .i_load_index      (i_in.load_index),
        .i_load_value      (i_in.load_value),
        .i_symbol_byte     (i_in.symbol_byte),
        .i_cfg_data        (i_cfg.data),
        .i_out_ready       (o_out.ready),
        .o_sts             (w_sts),
        .o_out_valid       (o_out.valid),
        .o_factor_position (o_out.factor_position),
        .o_factor_length   (o_out.factor_length),
        .o_status_code     (o_out.status_code),
        .o_last_of_item    (o_out.last_of_item)
    );

`ifndef SYNTH
    // a new item never starts with a result still held back
    a_pend_empty_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |-> !w_sts.pend_valid)
        else $error("item accepted with a pending result");

    // error results carry no factor
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.status_code != STS_FACTOR
        |-> o_out.factor_length == '0 && o_out.factor_position == '0)
        else $error("error result with nonzero factor");

    // a real factor covers at least one symbol
    a_factor_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.status_code == STS_FACTOR |-> o_out.factor_length != '0)
        else $error("empty factor emitted");

    // a held result stays unchanged until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> o_out.valid
        && $stable(o_out.factor_position) && $stable(o_out.factor_length)
        && $stable(o_out.status_code) && $stable(o_out.last_of_item))
        else $error("result changed while stalled");
`endif

endmodule

`default_nettype wire
